// ===== rtl/nmea_sentence_validator_macros.svh =====
// ----------------------------------------------------------------------------
// NMEA sentence validator assertion macros
// Implication and next-cycle checks, clocked on rising edge, async reset off.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_VALIDATOR_MACROS_SVH
`define NMEA_SENTENCE_VALIDATOR_MACROS_SVH

`ifndef ASSERT_OFF

`define NSV_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

`define NSV_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`else

`define NSV_ASSERT_IMPLY(label, clk, rst_n, a, b)

`define NSV_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== rtl/nsv_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence validator package
// Character constants, error and format codes, helper functions.
// ----------------------------------------------------------------------------
package nsv_pkg;

    localparam logic [7:0] MAX_LINE  = 8'd128;
    localparam logic [7:0] MIN_LINE  = 8'd9;

    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_G      = 8'h47;

    localparam logic [4:0] COMMA_MAX = 5'd31;

    localparam logic [3:0] ERR_NONE   = 4'd0;
    localparam logic [3:0] ERR_START  = 4'd1;
    localparam logic [3:0] ERR_HEADER = 4'd2;
    localparam logic [3:0] ERR_STRAY  = 4'd3;
    localparam logic [3:0] ERR_STAR   = 4'd4;
    localparam logic [3:0] ERR_CSUM   = 4'd5;
    localparam logic [3:0] ERR_FORMAT = 4'd6;
    localparam logic [3:0] ERR_FIELDS = 4'd7;
    localparam logic [3:0] ERR_LENGTH = 4'd8;

    localparam logic [1:0] FMT_GLL = 2'd0;
    localparam logic [1:0] FMT_WPL = 2'd1;
    localparam logic [1:0] FMT_RMC = 2'd2;
    localparam logic [1:0] FMT_GGA = 2'd3;

    localparam logic [4:0] FIELDS_GLL = 5'd7;
    localparam logic [4:0] FIELDS_WPL = 5'd4;
    localparam logic [4:0] FIELDS_RMC = 5'd12;
    localparam logic [4:0] FIELDS_GGA = 5'd15;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] code;
    } format_match_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic hex_digit_t hex_value(input logic [7:0] c);
        hex_digit_t h;
        h.ok    = 1'b0;
        h.value = 4'd0;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            h.ok    = 1'b1;
            h.value = c[3:0];
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            h.ok    = 1'b1;
            h.value = c[3:0] + 4'd9;
        end
        return h;
    endfunction

    function automatic format_match_t match_format(input logic [7:0] c0,
                                                   input logic [7:0] c1,
                                                   input logic [7:0] c2);
        format_match_t m;
        m.hit  = 1'b1;
        m.code = FMT_GLL;
        if ({c0, c1, c2} == {8'h47, 8'h4C, 8'h4C})
            m.code = FMT_GLL;
        else if ({c0, c1, c2} == {8'h57, 8'h50, 8'h4C})
            m.code = FMT_WPL;
        else if ({c0, c1, c2} == {8'h52, 8'h4D, 8'h43})
            m.code = FMT_RMC;
        else if ({c0, c1, c2} == {8'h47, 8'h47, 8'h41})
            m.code = FMT_GGA;
        else
            m.hit = 1'b0;
        return m;
    endfunction

    function automatic logic [4:0] wanted_fields(input logic [1:0] code);
        logic [4:0] n;
        unique case (code)
            FMT_GLL: n = FIELDS_GLL;
            FMT_WPL: n = FIELDS_WPL;
            FMT_RMC: n = FIELDS_RMC;
            FMT_GGA: n = FIELDS_GGA;
            default: n = FIELDS_GLL;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/nsv_if.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence validator channels
// Byte input channel and verdict output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nsv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface nsv_verdict_if;
    logic       valid;
    logic       ready;
    logic       sentence_ok;
    logic [3:0] error_code;
    logic [1:0] format_code;
    logic [7:0] talker_letter;
    logic [4:0] field_count;
    logic [7:0] computed_checksum;

    modport source (output valid, output sentence_ok, output error_code,
                    output format_code, output talker_letter, output field_count,
                    output computed_checksum, input ready);
    modport sink   (input valid, input sentence_ok, input error_code,
                    input format_code, input talker_letter, input field_count,
                    input computed_checksum, output ready);
endinterface

// ===== rtl/nmea_sentence_validator.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence validator
// Checks each newline-terminated sentence and reports one verdict per line.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received character per item; a newline (10) ends the line.
//   verdict carries one result per newline: pass flag, error code, format,
//   talker letter, comma count and the computed XOR checksum.
//   One item per cycle is sustained, except that a newline stalls while a
//   verdict is held and not taken. A verdict appears on verdict in the cycle
//   after its newline is accepted and is held in the output register until taken.
//   While a verdict waits, ordinary bytes are still accepted; only a newline
//   waits for the output register to free up (it may be taken the same cycle).
//   Reset clears all line state and the output valid flag; the first byte
//   after reset starts a new line.
//   Line state is also cleared by every newline.
// ----------------------------------------------------------------------------
`include "nmea_sentence_validator_macros.svh"

module nmea_sentence_validator
(
    input  logic          clk,
    input  logic          rst_n,
    nsv_byte_if.sink      rx,
    nsv_verdict_if.source verdict
);

    logic [7:0] pos_reg,   pos_next;
    logic [7:0] xor_reg,   xor_next;
    logic [7:0] tail_reg   [3];
    logic [7:0] tail_next  [3];
    logic [7:0] talker_reg, talker_next;
    logic [7:0] fmt_reg    [3];
    logic [7:0] fmt_next   [3];
    logic [4:0] comma_reg, comma_next;
    logic [3:0] ferr_reg,  ferr_next;

    logic       vld_reg;
    logic       ok_reg;
    logic [3:0] code_reg;
    logic [1:0] fcode_reg;
    logic [7:0] tlk_reg;
    logic [4:0] cnt_reg;
    logic [7:0] csum_reg;

    logic       out_free;
    logic       accept;
    logic       is_nl;
    logic       take_nl;
    logic [3:0] stream_err;
    logic [3:0] line_err;
    logic [7:0] b;

    nsv_pkg::format_match_t fm;
    nsv_pkg::hex_digit_t    hi;
    nsv_pkg::hex_digit_t    lo;

    assign b        = rx.data_byte;
    assign is_nl    = (b == nsv_pkg::CH_NL);
    assign out_free = !vld_reg || verdict.ready;
    assign rx.ready = out_free || !is_nl;
    assign accept   = rx.valid && rx.ready;
    assign take_nl  = accept && is_nl;

    assign fm = nsv_pkg::match_format(fmt_reg[0], fmt_reg[1], fmt_reg[2]);
    assign hi = nsv_pkg::hex_value(tail_reg[1]);
    assign lo = nsv_pkg::hex_value(tail_reg[0]);

    always_comb
    begin
        stream_err = nsv_pkg::ERR_NONE;
        priority if (pos_reg >= nsv_pkg::MAX_LINE)
            stream_err = nsv_pkg::ERR_LENGTH;
        else if ((pos_reg == 8'd0) && (b != nsv_pkg::CH_DOLLAR))
            stream_err = nsv_pkg::ERR_START;
        else if ((pos_reg == 8'd1) && (b != nsv_pkg::CH_G))
            stream_err = nsv_pkg::ERR_START;
        else if ((pos_reg >= 8'd2) && (pos_reg <= 8'd4) && !nsv_pkg::is_upper(b))
            stream_err = nsv_pkg::ERR_HEADER;
        else if ((pos_reg >= 8'd5) && (b == nsv_pkg::CH_DOLLAR))
            stream_err = nsv_pkg::ERR_STRAY;
        else if ((pos_reg >= 8'd8) && (tail_reg[2] == nsv_pkg::CH_STAR))
            stream_err = nsv_pkg::ERR_STRAY;
        else
            stream_err = nsv_pkg::ERR_NONE;
    end

    always_comb
    begin
        line_err = ferr_reg;
        if (ferr_reg == nsv_pkg::ERR_NONE)
        begin
            priority if (pos_reg < nsv_pkg::MIN_LINE)
                line_err = nsv_pkg::ERR_LENGTH;
            else if (tail_reg[2] != nsv_pkg::CH_STAR)
                line_err = nsv_pkg::ERR_STAR;
            else if ((tail_reg[1] == nsv_pkg::CH_STAR) || (tail_reg[0] == nsv_pkg::CH_STAR))
                line_err = nsv_pkg::ERR_STRAY;
            else if (!hi.ok || !lo.ok || ({hi.value, lo.value} != xor_reg))
                line_err = nsv_pkg::ERR_CSUM;
            else if (!fm.hit)
                line_err = nsv_pkg::ERR_FORMAT;
            else if (comma_reg != nsv_pkg::wanted_fields(fm.code))
                line_err = nsv_pkg::ERR_FIELDS;
            else
                line_err = nsv_pkg::ERR_NONE;
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        xor_next     = xor_reg;
        tail_next    = tail_reg;
        talker_next  = talker_reg;
        fmt_next     = fmt_reg;
        comma_next   = comma_reg;
        ferr_next    = ferr_reg;
        if (take_nl)
        begin
            pos_next    = 8'd0;
            xor_next    = 8'd0;
            tail_next   = '{8'd0, 8'd0, 8'd0};
            talker_next = 8'd0;
            fmt_next    = '{8'd0, 8'd0, 8'd0};
            comma_next  = 5'd0;
            ferr_next   = nsv_pkg::ERR_NONE;
        end
        else if (accept)
        begin
            if (ferr_reg == nsv_pkg::ERR_NONE)
                ferr_next = stream_err;
            if (pos_reg >= 8'd4)
                xor_next = xor_reg ^ tail_reg[2];
            if ((pos_reg >= 8'd9) && (tail_reg[2] == nsv_pkg::CH_COMMA)
                && (comma_reg < nsv_pkg::COMMA_MAX))
                comma_next = comma_reg + 5'd1;
            if (pos_reg == 8'd2)
                talker_next = b;
            unique case (pos_reg)
                8'd3:    fmt_next[0] = b;
                8'd4:    fmt_next[1] = b;
                8'd5:    fmt_next[2] = b;
                default: fmt_next    = fmt_reg;
            endcase
            tail_next[2] = tail_reg[1];
            tail_next[1] = tail_reg[0];
            tail_next[0] = b;
            if (pos_reg != 8'd255)
                pos_next = pos_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            xor_reg    <= 8'd0;
            tail_reg   <= '{8'd0, 8'd0, 8'd0};
            talker_reg <= 8'd0;
            fmt_reg    <= '{8'd0, 8'd0, 8'd0};
            comma_reg  <= 5'd0;
            ferr_reg   <= nsv_pkg::ERR_NONE;
            vld_reg    <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            xor_reg    <= xor_next;
            tail_reg   <= tail_next;
            talker_reg <= talker_next;
            fmt_reg    <= fmt_next;
            comma_reg  <= comma_next;
            ferr_reg   <= ferr_next;
            if (take_nl)
                vld_reg <= 1'b1;
            else if (verdict.ready)
                vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_nl)
        begin
            ok_reg    <= (line_err == nsv_pkg::ERR_NONE);
            code_reg  <= line_err;
            fcode_reg <= fm.hit ? fm.code : nsv_pkg::FMT_GLL;
            tlk_reg   <= talker_reg;
            cnt_reg   <= comma_reg;
            csum_reg  <= xor_reg;
        end
    end

    assign verdict.valid             = vld_reg;
    assign verdict.sentence_ok       = ok_reg;
    assign verdict.error_code        = code_reg;
    assign verdict.format_code       = fcode_reg;
    assign verdict.talker_letter     = tlk_reg;
    assign verdict.field_count       = cnt_reg;
    assign verdict.computed_checksum = csum_reg;

    `NSV_ASSERT_NEXT(a_nl_gives_verdict, clk, rst_n, take_nl, vld_reg)
    `NSV_ASSERT_NEXT(a_nl_clears_line, clk, rst_n, take_nl,
                     (pos_reg == 8'd0) && (ferr_reg == nsv_pkg::ERR_NONE))
    `NSV_ASSERT_NEXT(a_first_error_holds, clk, rst_n,
                     (ferr_reg != nsv_pkg::ERR_NONE) && !take_nl, $stable(ferr_reg))
    `NSV_ASSERT_IMPLY(a_ok_matches_code, clk, rst_n, vld_reg,
                      ok_reg == (code_reg == nsv_pkg::ERR_NONE))

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence validator testbench
// Streams directed and random sentences, with noise, through the byte channel
// under random gaps and output back-pressure. Each verdict is predicted per
// byte and checked field by field as it arrives.
// ----------------------------------------------------------------------------
module tb;

    localparam int ITEM_TARGET  = 1150;
    localparam int MIN_LINES    = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] CH_CR = 8'h0D;

    typedef struct packed {
        logic       ok;
        logic [3:0] err;
        logic [1:0] fmt;
        logic [7:0] talker;
        logic [4:0] fields;
        logic [7:0] csum;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nsv_byte_if    rx_ch ();
    nsv_verdict_if vd_ch ();

    nmea_sentence_validator dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .verdict (vd_ch)
    );

    logic [7:0] byte_q[$];
    logic [7:0] sent_buf[$];
    verdict_t   verdict_q[$];

    int   newline_cnt = 0;
    int   calm_mark = 0;
    int   mismatches = 0;
    int   cycles = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    logic rx_taken = 1'b0;
    logic drained = 1'b0;

    // per-line state of the verdict predictor
    logic [7:0] ln_pos;
    logic [7:0] ln_xor;
    logic [7:0] ln_talker;
    logic [7:0] ln_tail[3];
    logic [7:0] ln_fmt[3];
    logic [4:0] ln_commas;
    logic [3:0] ln_err;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void line_clear();
        ln_pos    = 8'd0;
        ln_xor    = 8'd0;
        ln_talker = 8'd0;
        ln_tail   = '{8'd0, 8'd0, 8'd0};
        ln_fmt    = '{8'd0, 8'd0, 8'd0};
        ln_commas = 5'd0;
        ln_err    = nsv_pkg::ERR_NONE;
    endfunction

    function automatic void flag_err(input logic [3:0] code);
        if (ln_err == nsv_pkg::ERR_NONE)
            ln_err = code;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - 48;
        if (c >= "A" && c <= "F")
            return int'(c) - 55;
        return -1;
    endfunction

    function automatic int fmt_index();
        case ({ln_fmt[0], ln_fmt[1], ln_fmt[2]})
            "GLL":   return int'(nsv_pkg::FMT_GLL);
            "WPL":   return int'(nsv_pkg::FMT_WPL);
            "RMC":   return int'(nsv_pkg::FMT_RMC);
            "GGA":   return int'(nsv_pkg::FMT_GGA);
            default: return -1;
        endcase
    endfunction

    function automatic logic [4:0] field_target(input int k);
        logic [1:0] code;
        code = k[1:0];
        case (code)
            nsv_pkg::FMT_GLL: return nsv_pkg::FIELDS_GLL;
            nsv_pkg::FMT_WPL: return nsv_pkg::FIELDS_WPL;
            nsv_pkg::FMT_RMC: return nsv_pkg::FIELDS_RMC;
            default:          return nsv_pkg::FIELDS_GGA;
        endcase
    endfunction

    function automatic logic [23:0] fmt_name(input int k);
        case (k)
            0:       return "GLL";
            1:       return "WPL";
            2:       return "RMC";
            default: return "GGA";
        endcase
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        verdict_t v;
        int fmt;
        int hi;
        int lo;
        logic [3:0] e;
        if (b != nsv_pkg::CH_NL)
        begin
            if (ln_pos >= nsv_pkg::MAX_LINE)
                flag_err(nsv_pkg::ERR_LENGTH);
            if (ln_pos == 8'd0 && b != nsv_pkg::CH_DOLLAR)
                flag_err(nsv_pkg::ERR_START);
            if (ln_pos == 8'd1 && b != nsv_pkg::CH_G)
                flag_err(nsv_pkg::ERR_START);
            if (ln_pos >= 8'd2 && ln_pos <= 8'd4 && !(b >= "A" && b <= "Z"))
                flag_err(nsv_pkg::ERR_HEADER);
            if (ln_pos >= 8'd5 && b == nsv_pkg::CH_DOLLAR)
                flag_err(nsv_pkg::ERR_STRAY);
            // byte three back leaves the tail and becomes body
            if (ln_pos >= 8'd8 && ln_tail[2] == nsv_pkg::CH_STAR)
                flag_err(nsv_pkg::ERR_STRAY);
            if (ln_pos >= 8'd4)
                ln_xor = ln_xor ^ ln_tail[2];
            if (ln_pos >= 8'd9 && ln_tail[2] == nsv_pkg::CH_COMMA
                && ln_commas != nsv_pkg::COMMA_MAX)
                ln_commas = ln_commas + 5'd1;
            if (ln_pos == 8'd2)
                ln_talker = b;
            if (ln_pos >= 8'd3 && ln_pos <= 8'd5)
                ln_fmt[2'(ln_pos - 8'd3)] = b;
            ln_tail[2] = ln_tail[1];
            ln_tail[1] = ln_tail[0];
            ln_tail[0] = b;
            if (ln_pos != 8'd255)
                ln_pos = ln_pos + 8'd1;
        end
        else
        begin
            fmt = fmt_index();
            e = ln_err;
            if (e == nsv_pkg::ERR_NONE)
            begin
                hi = hex_nibble(ln_tail[1]);
                lo = hex_nibble(ln_tail[0]);
                if (ln_pos < nsv_pkg::MIN_LINE)
                    e = nsv_pkg::ERR_LENGTH;
                else if (ln_tail[2] != nsv_pkg::CH_STAR)
                    e = nsv_pkg::ERR_STAR;
                else if (ln_tail[1] == nsv_pkg::CH_STAR || ln_tail[0] == nsv_pkg::CH_STAR)
                    e = nsv_pkg::ERR_STRAY;
                else if (hi < 0 || lo < 0 || (hi * 16 + lo) != int'(ln_xor))
                    e = nsv_pkg::ERR_CSUM;
                else if (fmt < 0)
                    e = nsv_pkg::ERR_FORMAT;
                else if (ln_commas != field_target(fmt))
                    e = nsv_pkg::ERR_FIELDS;
            end
            v.ok     = (e == nsv_pkg::ERR_NONE);
            v.err    = e;
            v.fmt    = (fmt < 0) ? nsv_pkg::FMT_GLL : fmt[1:0];
            v.talker = ln_talker;
            v.fields = ln_commas;
            v.csum   = ln_xor;
            verdict_q = {verdict_q, v};
            line_clear();
        end
    endfunction

    // ---- sentence construction ----

    function automatic void buf_add(input logic [7:0] b);
        sent_buf = {sent_buf, b};
    endfunction

    function automatic logic [7:0] upper();
        return 8'h41 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] field_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 8'h30 + 8'($urandom_range(0, 9));
        if (r < 8)
            return upper();
        if (r == 8)
            return ".";
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + n) : (8'h37 + n);
    endfunction

    function automatic void stream_byte(input logic [7:0] b);
        byte_q = {byte_q, b};
        if (b == nsv_pkg::CH_NL)
            newline_cnt++;
    endfunction

    function automatic void build(input logic [23:0] fmt3, input logic [7:0] talker,
                                  input int ncommas, input int maxflen);
        int i;
        int j;
        int n;
        sent_buf.delete();
        buf_add(nsv_pkg::CH_DOLLAR);
        buf_add(nsv_pkg::CH_G);
        buf_add(talker);
        buf_add(fmt3[23:16]);
        buf_add(fmt3[15:8]);
        buf_add(fmt3[7:0]);
        for (i = 0; i < ncommas; i++)
        begin
            buf_add(nsv_pkg::CH_COMMA);
            n = $urandom_range(0, maxflen);
            for (j = 0; j < n; j++)
                buf_add(field_char());
        end
    endfunction

    function automatic void pad(input int n);
        int i;
        for (i = 0; i < n; i++)
            buf_add(field_char());
    endfunction

    function automatic void seal(input logic [7:0] flip);
        logic [7:0] cs;
        int i;
        cs = 8'd0;
        for (i = 1; i < sent_buf.size(); i++)
            cs = cs ^ sent_buf[i];
        cs = cs ^ flip;
        buf_add(nsv_pkg::CH_STAR);
        buf_add(hex_char(cs[7:4]));
        buf_add(hex_char(cs[3:0]));
    endfunction

    function automatic void trim_line(input int n);
        while (sent_buf.size() > n)
            void'(sent_buf.pop_back());
    endfunction

    function automatic void ship();
        foreach (sent_buf[i])
            stream_byte(sent_buf[i]);
        stream_byte(nsv_pkg::CH_NL);
    endfunction

    function automatic void random_sentence();
        int kind;
        int k;
        int nc;
        int pos;
        logic [7:0] flip;
        kind = $urandom_range(0, 99);
        k = $urandom_range(0, 4);
        nc = (k == 4) ? $urandom_range(0, 16) : int'(field_target(k));
        if (kind < 10)
            nc = $urandom_range(0, 20);
        build((k == 4) ? {upper(), upper(), upper()} : fmt_name(k), upper(), nc, 3);
        if (kind >= 90 && kind < 93)
            pad($urandom_range(100, 200));
        flip = (kind >= 10 && kind < 20) ? 8'($urandom_range(1, 255)) : 8'h00;
        seal(flip);
        if (kind >= 20 && kind < 25)
        begin
            pos = sent_buf.size() - 1 - $urandom_range(0, 1);
            sent_buf[pos] = $urandom_range(0, 1) ? 8'h61 + 8'($urandom_range(0, 5))
                                                 : 8'h47 + 8'($urandom_range(0, 19));
        end
        else if (kind >= 25 && kind < 32)
        begin
            pos = $urandom_range(5, sent_buf.size() - 3);
            sent_buf.insert(pos, $urandom_range(0, 1) ? nsv_pkg::CH_DOLLAR
                                                      : nsv_pkg::CH_STAR);
        end
        else if (kind >= 32 && kind < 38)
        begin
            case ($urandom_range(0, 2))
                0:       sent_buf[sent_buf.size() - 3] = field_char();
                1:       buf_add($urandom_range(0, 1) ? CH_CR : field_char());
                default: sent_buf.delete(sent_buf.size() - 3);
            endcase
        end
        else if (kind >= 38 && kind < 45)
            sent_buf[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
        else if (kind >= 45 && kind < 50)
            trim_line($urandom_range(0, 8));
        else if (kind >= 50 && kind < 53)
            sent_buf[sent_buf.size() - 1 - $urandom_range(0, 1)] = nsv_pkg::CH_STAR;
        ship();
    endfunction

    function automatic void noise_burst();
        int n;
        int i;
        n = $urandom_range(1, 24);
        for (i = 0; i < n; i++)
            stream_byte(($urandom_range(0, 5) == 0) ? nsv_pkg::CH_NL
                                                    : 8'($urandom_range(0, 255)));
    endfunction

    function automatic logic calm_phase();
        return byte_q.size() < calm_mark;
    endfunction

    // ---- byte driver ----

    always @(negedge clk)
    begin
        if (!rst_n)
            rx_ch.valid <= 1'b0;
        else if (!rx_ch.valid || rx_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                rx_ch.valid <= 1'b0;
            end
            else if (byte_q.size() != 0 && !calm_phase() && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 5);
                rx_ch.valid <= 1'b0;
            end
            else if (byte_q.size() != 0)
            begin
                rx_ch.data_byte <= byte_q.pop_front();
                rx_ch.valid <= 1'b1;
            end
            else
                rx_ch.valid <= 1'b0;
        end
    end

    // ---- verdict back-pressure ----

    always @(negedge clk)
    begin
        if (!rst_n)
            vd_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            vd_ch.ready <= 1'b0;
        end
        else if (!calm_phase() && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            vd_ch.ready <= 1'b0;
        end
        else
            vd_ch.ready <= 1'b1;
    end

    // ---- monitor and checker ----

    always @(posedge clk)
    begin : watch
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            rx_taken <= 1'b0;
            drained <= 1'b0;
        end
        else
        begin
            rx_taken <= rx_ch.valid && rx_ch.ready;
            if (vd_ch.valid && vd_ch.ready)
            begin
                got.ok     = vd_ch.sentence_ok;
                got.err    = vd_ch.error_code;
                got.fmt    = vd_ch.format_code;
                got.talker = vd_ch.talker_letter;
                got.fields = vd_ch.field_count;
                got.csum   = vd_ch.computed_checksum;
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected ok=%0d err=%0d fmt=%0d tlk=%02h fld=%0d cs=%02h",
                                 got.ok, got.err, got.fmt, got.talker, got.fields,
                                 got.csum);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("verdict mismatch at %0t", $realtime);
                            $display("  expected ok=%0d err=%0d fmt=%0d tlk=%02h fld=%0d cs=%02h",
                                     want.ok, want.err, want.fmt, want.talker,
                                     want.fields, want.csum);
                            $display("  actual   ok=%0d err=%0d fmt=%0d tlk=%02h fld=%0d cs=%02h",
                                     got.ok, got.err, got.fmt, got.talker,
                                     got.fields, got.csum);
                        end
                    end
                end
            end
            if (rx_ch.valid && rx_ch.ready)
                predict_byte(rx_ch.data_byte);
            drained <= byte_q.size() == 0 && !rx_ch.valid && verdict_q.size() == 0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---- stimulus and end of run ----

    initial
    begin
        rx_ch.valid = 1'b0;
        rx_ch.data_byte = 8'd0;
        vd_ch.ready = 1'b0;
        line_clear();

        // four supported formats, correct field counts
        build("GLL", "P", 7, 1);  seal(8'h00); ship();
        build("WPL", "N", 4, 1);  seal(8'h00); ship();
        build("RMC", "L", 12, 1); seal(8'h00); ship();
        build("GGA", "Z", 15, 1); seal(8'h00); ship();
        // empty line, short line
        stream_byte(nsv_pkg::CH_NL);
        build("GLL", "A", 7, 0); trim_line(5); ship();
        // start and header letters
        build("GLL", "P", 7, 0); seal(8'h00); sent_buf[0] = "#"; ship();
        build("GLL", "P", 7, 0); seal(8'h00); sent_buf[1] = "X"; ship();
        build("GLL", "P", 7, 0); seal(8'h00); sent_buf[3] = "p"; ship();
        // bad byte in the last format letter, unknown format
        build("GLx", "P", 7, 0); seal(8'h00); ship();
        build("XYZ", "P", 7, 0); seal(8'h00); ship();
        // wrong field count, comma count saturation
        build("GGA", "P", 14, 0); seal(8'h00); ship();
        build("GLL", "P", 40, 0); seal(8'h00); ship();
        // checksum mismatch, lowercase and non-hex digits
        build("RMC", "P", 12, 0); seal(8'h01); ship();
        build("WPL", "P", 4, 0); seal(8'h00); sent_buf[sent_buf.size() - 1] = "a"; ship();
        build("WPL", "P", 4, 0); seal(8'h00); sent_buf[sent_buf.size() - 2] = "G"; ship();
        // no star, star too early, second star in the tail, stray dollar, CR
        build("GLL", "P", 7, 0); seal(8'h00); sent_buf[sent_buf.size() - 3] = "0"; ship();
        build("GLL", "P", 7, 0); seal(8'h00); buf_add("A"); ship();
        build("GLL", "P", 7, 0); seal(8'h00);
        sent_buf[sent_buf.size() - 1] = nsv_pkg::CH_STAR; ship();
        build("GLL", "P", 7, 0); seal(8'h00); sent_buf.insert(8, nsv_pkg::CH_DOLLAR); ship();
        build("GLL", "P", 7, 0); seal(8'h00); buf_add(CH_CR); ship();
        // length limit edges
        build("GLL", "B", 7, 0); pad(112); seal(8'h00); ship();
        build("GLL", "B", 7, 0); pad(113); seal(8'h00); ship();
        // binary bytes inside a field
        build("GLL", "P", 7, 1);
        buf_add(8'hFF);
        buf_add(8'h00);
        buf_add(8'h80);
        buf_add(8'h7F);
        seal(8'h00);
        ship();

        while (byte_q.size() < ITEM_TARGET || newline_cnt < MIN_LINES)
        begin
            if ($urandom_range(0, 7) == 0)
                noise_burst();
            else
                random_sentence();
        end
        calm_mark = byte_q.size() / 8;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!drained)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && verdict_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== nmea_sentence_validator.f =====
+incdir+rtl
rtl/nsv_pkg.sv
rtl/nsv_if.sv
rtl/nmea_sentence_validator.sv
tb/sv/tb.sv
